[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check prop on every rising clock edge while reset is released
`define SFG_ASSERT(name, clock, resetn, prop) \
  name: assert property (@(posedge clock) disable iff (!resetn) prop) \
    else $error("assertion failed");

// check prop on every rising clock edge, reset included
`define SFG_ASSERT_NR(name, clock, prop) \
  name: assert property (@(posedge clock) prop) \
    else $error("assertion failed");

`else

`define SFG_ASSERT(name, clock, resetn, prop)
`define SFG_ASSERT_NR(name, clock, prop)

`endif

`endif

[rtl/core/sfg_pkg.sv]
// ----------------------------------------------------------------------------
// sfg_pkg
// Payload types, register indexes and constants of the spring force generator.
// ----------------------------------------------------------------------------
package sfg_pkg;

  localparam int COORD_WIDTH    = 32;
  localparam int OUT_WIDTH      = 32;
  localparam int CFG_REG_WIDTH  = 31;
  localparam int CFG_IDX_WIDTH  = 8;
  localparam int CFG_DATA_WIDTH = 32;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_REST_LENGTH      = 8'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPRING_STIFFNESS = 8'd1;

  localparam logic [CFG_REG_WIDTH-1:0] REST_LENGTH_RESET = 31'd65536;
  localparam logic [CFG_REG_WIDTH-1:0] STIFFNESS_RESET   = 31'd65536;

  localparam logic [OUT_WIDTH-1:0] FORCE_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [OUT_WIDTH-1:0] FORCE_NEG_MAX = 32'h8000_0000;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic signed [COORD_WIDTH-1:0] end_z;
  } sfg_in_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] force_x;
    logic signed [OUT_WIDTH-1:0] force_y;
    logic signed [OUT_WIDTH-1:0] force_z;
    logic                        clipped;
  } sfg_out_t;

endpackage

[rtl/core/spring_force_generator.sv]
// ----------------------------------------------------------------------------
// spring_force_generator
// Hooke spring force for one particle pair per request, fixed-point pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : request channel, one particle position and the other end per item.
//           A request is taken when in_valid is high and in_stall is low.
//   out_* : result channel, one force vector plus a clipped flag per request.
//           A result is taken when out_valid is high and out_stall is low.
//   cfg_* : register writes (rest length, stiffness), cfg_ready is always high.
//           Write only while the pipeline is empty.
// Throughput is one request per cycle while in_stall is low. The square root
// resolves one root bit per stage (COORD_WIDTH + 1 stages), each force
// component resolves one quotient bit per stage (32 stages), and 13 stages
// of multiply and glue lie around them.
// A two-entry output buffer decouples the sides: in_stall is high only when
// both the output register and the skid entry are full, so the pipeline keeps
// taking requests while one finished result waits. Synchronous reset empties
// the pipeline and loads both registers with 1.0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spring_force_generator
  import sfg_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  sfg_in_t                   in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output sfg_out_t                  out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int H    = (CW + 1) / 2;
  localparam int SQW  = 2 * CW;
  localparam int LW   = CW + 1;
  localparam int SUMW = 2 * LW;
  localparam int MW   = (LW > CFG_REG_WIDTH) ? LW : CFG_REG_WIDTH;
  localparam int MH   = (MW + 1) / 2;
  localparam int PW   = MW + CFG_REG_WIDTH;
  localparam int MAGW = PW - FRAC_BITS;
  localparam int GH   = (MAGW + 1) / 2;
  localparam int NW   = CW + MAGW;
  localparam int QW   = OUT_WIDTH;
  localparam int NHW  = NW - QW;

  // configuration
  logic [CFG_REG_WIDTH-1:0] rest_len_r;
  logic [CFG_REG_WIDTH-1:0] stiff_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_len_r <= REST_LENGTH_RESET;
      stiff_r    <= STIFFNESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_REST_LENGTH:      rest_len_r <= cfg_wdata[CFG_REG_WIDTH-1:0];
        REG_SPRING_STIFFNESS: stiff_r    <= cfg_wdata[CFG_REG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // flow control
  logic     adv;
  logic     out_v_r;
  logic     skid_v_r;
  sfg_out_t out_data_r;
  sfg_out_t skid_data_r;

  assign adv       = !skid_v_r;
  assign in_stall  = skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  // stage registers
  logic                      s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic [2:0][DW-1:0]        s1_diff_r, s1_diff_nxt;
  logic [2:0][DW-1:0]        s2_abs;
  logic [2:0][CW-1:0]        s2_dmag_r, s2_dmag_nxt;
  logic [2:0]                s2_neg_r, s2_neg_nxt;
  logic [2:0][CW+H-1:0]      s3_pl_r, s3_pl_nxt;
  logic [2:0][2*CW-H-1:0]    s3_ph_r, s3_ph_nxt;
  logic [2:0][CW-1:0]        s3_dmag_r;
  logic [2:0]                s3_neg_r;
  logic [2:0][SQW-1:0]       s4_sq_r, s4_sq_nxt;
  logic [2:0][CW-1:0]        s4_dmag_r;
  logic [2:0]                s4_neg_r;
  logic [SUMW-1:0]           s5_sum_r, s5_sum_nxt;
  logic [2:0][CW-1:0]        s5_dmag_r;
  logic [2:0]                s5_neg_r;

  logic                      a_v_r;
  logic [LW-1:0]             a_len_r;
  logic [MW-1:0]             a_m_r, a_m_nxt;
  logic                      a_zero_r;
  logic [2:0][CW-1:0]        a_dmag_r;
  logic [2:0]                a_neg_r;
  logic [MW-1:0]             a_len_e, a_rest_e;

  logic                      b_v_r;
  logic [MH+CFG_REG_WIDTH-1:0]    b_pl_r, b_pl_nxt;
  logic [MW-MH+CFG_REG_WIDTH-1:0] b_ph_r, b_ph_nxt;
  logic [LW-1:0]             b_len_r;
  logic                      b_zero_r;
  logic [2:0][CW-1:0]        b_dmag_r;
  logic [2:0]                b_neg_r;

  logic                      c_v_r;
  logic [PW-1:0]             c_prod;
  logic [MAGW-1:0]           c_smag_r, c_smag_nxt;
  logic [LW-1:0]             c_len_r;
  logic                      c_zero_r;
  logic [2:0][CW-1:0]        c_dmag_r;
  logic [2:0]                c_neg_r;

  logic                      d_v_r;
  logic [2:0][CW+GH-1:0]     d_pl_r, d_pl_nxt;
  logic [2:0][NW-GH-1:0]     d_ph_r, d_ph_nxt;
  logic [LW-1:0]             d_len_r;
  logic                      d_zero_r;
  logic [2:0]                d_neg_r;

  logic                      e_v_r;
  logic [2:0][NW-1:0]        e_num_r, e_num_nxt;
  logic [LW-1:0]             e_len_r;
  logic                      e_zero_r;
  logic [2:0]                e_neg_r;

  logic                      f_v_r;
  logic [2:0][NHW-1:0]       f_hi;
  logic [2:0][LW-1:0]        f_rem_r, f_rem_nxt;
  logic [2:0][QW-1:0]        f_sh_r, f_sh_nxt;
  logic [2:0]                f_ovf_r, f_ovf_nxt;
  logic [LW-1:0]             f_len_r;
  logic                      f_zero_r;
  logic [2:0]                f_neg_r;

  logic                      g_v_r;
  sfg_out_t                  g_data_r, g_data_nxt;
  logic [2:0][OUT_WIDTH-1:0] g_force;
  logic [2:0]                g_clip;

  // square root stage outputs
  wire [SUMW-1:0]            rt_rad  [LW];
  wire [LW-1:0]              rt_rem  [LW];
  wire [LW-1:0]              rt_root [LW];
  wire [2:0][CW-1:0]         rt_dmag [LW];
  wire [2:0]                 rt_neg  [LW];
  wire                       rt_v    [LW];

  // quotient stage outputs
  wire [2:0][LW-1:0]         dv_rem  [QW];
  wire [2:0][QW-1:0]         dv_sh   [QW];
  wire [2:0]                 dv_ovf  [QW];
  wire [2:0]                 dv_neg  [QW];
  wire [LW-1:0]              dv_len  [QW];
  wire                       dv_zero [QW];
  wire                       dv_v    [QW];

  logic [2:0][CW-1:0] in_pos, in_end;
  assign in_pos = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
  assign in_end = {in_data.end_z, in_data.end_y, in_data.end_x};

  // difference, magnitude, squares, sum
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_diff_nxt[i] = {in_pos[i][CW-1], in_pos[i]} - {in_end[i][CW-1], in_end[i]};
      s2_neg_nxt[i]  = s1_diff_r[i][DW-1];
      s2_abs[i]      = s2_neg_nxt[i] ? (~s1_diff_r[i] + DW'(1)) : s1_diff_r[i];
      s2_dmag_nxt[i] = s2_abs[i][CW-1:0];
      s3_pl_nxt[i]   = s2_dmag_r[i] * s2_dmag_r[i][H-1:0];
      s3_ph_nxt[i]   = s2_dmag_r[i] * s2_dmag_r[i][CW-1:H];
      s4_sq_nxt[i]   = SQW'(s3_pl_r[i]) + (SQW'(s3_ph_r[i]) << H);
    end
    s5_sum_nxt = SUMW'(s4_sq_r[0]) + SUMW'(s4_sq_r[1]) + SUMW'(s4_sq_r[2]);
  end

  // |L - rest|, spring magnitude, per-lane numerators, overflow split
  always_comb begin
    a_len_e  = MW'(rt_root[LW-1]);
    a_rest_e = MW'(rest_len_r);
    a_m_nxt  = (a_len_e >= a_rest_e) ? (a_len_e - a_rest_e) : (a_rest_e - a_len_e);
    b_pl_nxt = a_m_r[MH-1:0] * stiff_r;
    b_ph_nxt = a_m_r[MW-1:MH] * stiff_r;
    c_prod   = PW'(b_pl_r) + (PW'(b_ph_r) << MH);
    c_smag_nxt = c_prod[PW-1:FRAC_BITS];
    for (int i = 0; i < 3; i++) begin
      d_pl_nxt[i]  = c_dmag_r[i] * c_smag_r[GH-1:0];
      d_ph_nxt[i]  = c_dmag_r[i] * c_smag_r[MAGW-1:GH];
      e_num_nxt[i] = NW'(d_pl_r[i]) + (NW'(d_ph_r[i]) << GH);
      // quotient of 2^QW or more saturates either way
      f_hi[i]      = e_num_r[i][NW-1:QW];
      f_ovf_nxt[i] = f_hi[i] >= NHW'(e_len_r);
      f_rem_nxt[i] = f_hi[i][LW-1:0];
      f_sh_nxt[i]  = e_num_r[i][QW-1:0];
    end
  end

  // negate and saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_zero[QW-1]) begin
        g_clip[i]  = 1'b0;
        g_force[i] = '0;
      end else if (dv_neg[QW-1][i]) begin
        g_clip[i]  = dv_ovf[QW-1][i] || dv_sh[QW-1][i][QW-1];
        g_force[i] = g_clip[i] ? FORCE_POS_MAX : dv_sh[QW-1][i];
      end else begin
        g_clip[i]  = dv_ovf[QW-1][i] || (dv_sh[QW-1][i] > FORCE_NEG_MAX);
        g_force[i] = g_clip[i] ? FORCE_NEG_MAX : (QW'(0) - dv_sh[QW-1][i]);
      end
    end
    g_data_nxt.force_x = g_force[0];
    g_data_nxt.force_y = g_force[1];
    g_data_nxt.force_z = g_force[2];
    g_data_nxt.clipped = |g_clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      a_v_r  <= 1'b0;
      b_v_r  <= 1'b0;
      c_v_r  <= 1'b0;
      d_v_r  <= 1'b0;
      e_v_r  <= 1'b0;
      f_v_r  <= 1'b0;
      g_v_r  <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      a_v_r  <= rt_v[LW-1];
      b_v_r  <= a_v_r;
      c_v_r  <= b_v_r;
      d_v_r  <= c_v_r;
      e_v_r  <= d_v_r;
      f_v_r  <= e_v_r;
      g_v_r  <= dv_v[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_diff_r <= s1_diff_nxt;
      s2_dmag_r <= s2_dmag_nxt;
      s2_neg_r  <= s2_neg_nxt;
      s3_pl_r   <= s3_pl_nxt;
      s3_ph_r   <= s3_ph_nxt;
      s3_dmag_r <= s2_dmag_r;
      s3_neg_r  <= s2_neg_r;
      s4_sq_r   <= s4_sq_nxt;
      s4_dmag_r <= s3_dmag_r;
      s4_neg_r  <= s3_neg_r;
      s5_sum_r  <= s5_sum_nxt;
      s5_dmag_r <= s4_dmag_r;
      s5_neg_r  <= s4_neg_r;

      a_len_r   <= rt_root[LW-1];
      a_m_r     <= a_m_nxt;
      a_zero_r  <= (rt_root[LW-1] == '0);
      a_dmag_r  <= rt_dmag[LW-1];
      a_neg_r   <= rt_neg[LW-1];

      b_pl_r    <= b_pl_nxt;
      b_ph_r    <= b_ph_nxt;
      b_len_r   <= a_len_r;
      b_zero_r  <= a_zero_r;
      b_dmag_r  <= a_dmag_r;
      b_neg_r   <= a_neg_r;

      c_smag_r  <= c_smag_nxt;
      c_len_r   <= b_len_r;
      c_zero_r  <= b_zero_r;
      c_dmag_r  <= b_dmag_r;
      c_neg_r   <= b_neg_r;

      d_pl_r    <= d_pl_nxt;
      d_ph_r    <= d_ph_nxt;
      d_len_r   <= c_len_r;
      d_zero_r  <= c_zero_r;
      d_neg_r   <= c_neg_r;

      e_num_r   <= e_num_nxt;
      e_len_r   <= d_len_r;
      e_zero_r  <= d_zero_r;
      e_neg_r   <= d_neg_r;

      f_rem_r   <= f_rem_nxt;
      f_sh_r    <= f_sh_nxt;
      f_ovf_r   <= f_ovf_nxt;
      f_len_r   <= e_len_r;
      f_zero_r  <= e_zero_r;
      f_neg_r   <= e_neg_r;

      g_data_r  <= g_data_nxt;
    end
  end

  // square root, one root bit per stage, two radicand bits consumed per stage
  for (genvar j = 0; j < LW; j++) begin : g_sqrt
    logic [SUMW-1:0]    rad_i;
    logic [LW-1:0]      rem_i, root_i;
    logic [2:0][CW-1:0] dmag_i;
    logic [2:0]         neg_i;
    logic               v_i;
    logic [LW+1:0]      cand, trial;
    logic               ge;
    logic [SUMW-1:0]    rad_r;
    logic [LW-1:0]      rem_r, rem_nxt, root_r, root_nxt;
    logic [2:0][CW-1:0] dmag_r;
    logic [2:0]         neg_r;
    logic               v_r;

    if (j == 0) begin : g_head
      assign rad_i  = s5_sum_r;
      assign rem_i  = '0;
      assign root_i = '0;
      assign dmag_i = s5_dmag_r;
      assign neg_i  = s5_neg_r;
      assign v_i    = s5_v_r;
    end else begin : g_body
      assign rad_i  = rt_rad[j-1];
      assign rem_i  = rt_rem[j-1];
      assign root_i = rt_root[j-1];
      assign dmag_i = rt_dmag[j-1];
      assign neg_i  = rt_neg[j-1];
      assign v_i    = rt_v[j-1];
    end

    always_comb begin
      cand     = {rem_i, rad_i[SUMW-1 -: 2]};
      trial    = {root_i, 2'b01};
      ge       = (cand >= trial);
      rem_nxt  = ge ? LW'(cand - trial) : cand[LW-1:0];
      root_nxt = {root_i[LW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (adv) begin
        v_r <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rad_r  <= rad_i << 2;
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        dmag_r <= dmag_i;
        neg_r  <= neg_i;
      end
    end

    assign rt_rad[j]  = rad_r;
    assign rt_rem[j]  = rem_r;
    assign rt_root[j] = root_r;
    assign rt_dmag[j] = dmag_r;
    assign rt_neg[j]  = neg_r;
    assign rt_v[j]    = v_r;
  end

  // restoring division by L, one quotient bit per stage on all three lanes
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [2:0][LW-1:0] rem_i;
    logic [2:0][QW-1:0] sh_i;
    logic [2:0]         ovf_i, neg_i;
    logic [LW-1:0]      len_i;
    logic               zero_i, v_i;
    logic [2:0][LW:0]   cand;
    logic [2:0]         ge;
    logic [2:0][LW-1:0] rem_r, rem_nxt;
    logic [2:0][QW-1:0] sh_r, sh_nxt;
    logic [2:0]         ovf_r, neg_r;
    logic [LW-1:0]      len_r;
    logic               zero_r, v_r;

    if (j == 0) begin : g_head
      assign rem_i  = f_rem_r;
      assign sh_i   = f_sh_r;
      assign ovf_i  = f_ovf_r;
      assign neg_i  = f_neg_r;
      assign len_i  = f_len_r;
      assign zero_i = f_zero_r;
      assign v_i    = f_v_r;
    end else begin : g_body
      assign rem_i  = dv_rem[j-1];
      assign sh_i   = dv_sh[j-1];
      assign ovf_i  = dv_ovf[j-1];
      assign neg_i  = dv_neg[j-1];
      assign len_i  = dv_len[j-1];
      assign zero_i = dv_zero[j-1];
      assign v_i    = dv_v[j-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        cand[i]    = {rem_i[i], sh_i[i][QW-1]};
        ge[i]      = (cand[i] >= {1'b0, len_i});
        rem_nxt[i] = ge[i] ? LW'(cand[i] - {1'b0, len_i}) : cand[i][LW-1:0];
        // shift the numerator out at the top, the quotient in at the bottom
        sh_nxt[i]  = {sh_i[i][QW-2:0], ge[i]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (adv) begin
        v_r <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r  <= rem_nxt;
        sh_r   <= sh_nxt;
        ovf_r  <= ovf_i;
        neg_r  <= neg_i;
        len_r  <= len_i;
        zero_r <= zero_i;
      end
    end

    assign dv_rem[j]  = rem_r;
    assign dv_sh[j]   = sh_r;
    assign dv_ovf[j]  = ovf_r;
    assign dv_neg[j]  = neg_r;
    assign dv_len[j]  = len_r;
    assign dv_zero[j] = zero_r;
    assign dv_v[j]    = v_r;
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || !out_stall) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= g_v_r;
      end
    end else if (g_v_r && adv) begin
      // hold the new result beside the stalled one
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || !out_stall) begin
      out_data_r <= skid_v_r ? skid_data_r : g_data_r;
    end else if (g_v_r && adv) begin
      skid_data_r <= g_data_r;
    end
  end

  logic out_sat;
  assign out_sat = (out_data_r.force_x == FORCE_POS_MAX) ||
                   (out_data_r.force_x == FORCE_NEG_MAX) ||
                   (out_data_r.force_y == FORCE_POS_MAX) ||
                   (out_data_r.force_y == FORCE_NEG_MAX) ||
                   (out_data_r.force_z == FORCE_POS_MAX) ||
                   (out_data_r.force_z == FORCE_NEG_MAX);

  `SFG_ASSERT(a_skid_needs_out, clk, rst_n, skid_v_r |-> out_v_r)
  `SFG_ASSERT(a_skid_fills_on_stall, clk, rst_n, $rose(skid_v_r) |-> $past(out_stall))
  `SFG_ASSERT(a_clip_saturates, clk, rst_n, out_v_r && out_data_r.clipped |-> out_sat)
  `SFG_ASSERT_NR(a_reset_empties, clk, !rst_n |=> !out_v_r && !skid_v_r)

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the spring force generator: random and directed
// particle pairs under several rest length and stiffness settings, with
// sender gaps and receiver stalls, each force checked against a local model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import sfg_pkg::*;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_UNUSED = 8'd2;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 120;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  sfg_in_t                   in_data;
  logic                      out_valid;
  logic                      out_stall;
  sfg_out_t                  out_data;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_WIDTH-1:0]  cfg_index;
  logic [CFG_DATA_WIDTH-1:0] cfg_wdata;

  logic [30:0] rest_len_q;
  logic [30:0] stiffness_q;
  sfg_out_t    force_queue[$];
  int          idle_pct;
  int          stall_pct;
  int          mismatch_cnt;
  int          result_cnt;
  int          request_cnt;
  int          clip_cnt;
  int          quiet_cycles;

  spring_force_generator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic sfg_out_t spring_force(sfg_in_t r);
    logic signed [31:0] p[3];
    logic signed [31:0] e[3];
    logic signed [32:0] d;
    logic [32:0]        ad[3];
    logic               neg[3];
    logic [127:0]       sum;
    logic [127:0]       prod;
    logic [127:0]       mag;
    logic [127:0]       q;
    logic [63:0]        len;
    logic [63:0]        cand;
    logic [63:0]        m;
    logic [31:0]        f[3];
    logic               clip;
    sfg_out_t           res;
    p[0] = r.pos_x; p[1] = r.pos_y; p[2] = r.pos_z;
    e[0] = r.end_x; e[1] = r.end_y; e[2] = r.end_z;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      d = $signed({p[i][31], p[i]}) - $signed({e[i][31], e[i]});
      neg[i] = d[32];
      ad[i] = neg[i] ? 33'(-d) : 33'(d);
      sum = sum + 128'(ad[i]) * 128'(ad[i]);
    end
    len = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = len | (64'd1 << b);
      if (128'(cand) * 128'(cand) <= sum) len = cand;
    end
    res = '0;
    if (len == 0) return res;
    m = (len >= 64'(rest_len_q)) ? len - 64'(rest_len_q) : 64'(rest_len_q) - len;
    prod = 128'(m) * 128'(stiffness_q);
    mag = prod >> 16;
    clip = 1'b0;
    for (int i = 0; i < 3; i++) begin
      q = (128'(ad[i]) * mag) / 128'(len);
      if (neg[i]) begin
        if (q > 128'(FORCE_POS_MAX)) begin
          f[i] = FORCE_POS_MAX; clip = 1'b1;
        end else begin
          f[i] = q[31:0];
        end
      end else begin
        if (q > 128'(FORCE_NEG_MAX)) begin
          f[i] = FORCE_NEG_MAX; clip = 1'b1;
        end else begin
          f[i] = 32'(-q[31:0]);
        end
      end
    end
    res.force_x = f[0];
    res.force_y = f[1];
    res.force_z = f[2];
    res.clipped = clip;
    return res;
  endfunction

  // receiver stall pattern
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    sfg_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      result_cnt <= result_cnt + 1;
      if (force_queue.size() == 0) begin
        mismatch_cnt = mismatch_cnt + 1;
        if (mismatch_cnt <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = force_queue.pop_front();
        if (want.clipped) clip_cnt <= clip_cnt + 1;
        if (out_data.force_x !== want.force_x || out_data.force_y !== want.force_y ||
            out_data.force_z !== want.force_z || out_data.clipped !== want.clipped) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= 10)
            $display("force mismatch: expected x=%h y=%h z=%h clip=%b, got x=%h y=%h z=%h clip=%b",
                     want.force_x, want.force_y, want.force_z, want.clipped,
                     out_data.force_x, out_data.force_y, out_data.force_z,
                     out_data.clipped);
        end
      end
    end
  end

  // cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", force_queue.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_pair(sfg_in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    force_queue.push_back(spring_force(item));
    request_cnt = request_cnt + 1;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
  endtask

  // hold off until the pipeline is empty
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (force_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_REST_LENGTH) rest_len_q = val[30:0];
    else if (idx == REG_SPRING_STIFFNESS) stiffness_q = val[30:0];
  endtask

  function automatic sfg_in_t make_pair(int kind);
    sfg_in_t it;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    case (kind)
      0, 1, 2, 3: begin
        // anchor anywhere, particle close by
        it.pos_x = it.end_x + $signed(32'($urandom_range(32'h3FFFFF)) - 32'h200000);
        it.pos_y = it.end_y + $signed(32'($urandom_range(32'h3FFFFF)) - 32'h200000);
        it.pos_z = it.end_z + $signed(32'($urandom_range(32'h3FFFFF)) - 32'h200000);
      end
      4: begin
        it.pos_x = it.end_x; it.pos_y = it.end_y; it.pos_z = it.end_z;
      end
      5: begin
        it.pos_y = it.end_y; it.pos_z = it.end_z;
      end
      default: ;
    endcase
    return it;
  endfunction

  task automatic test_directed;
    sfg_in_t it;
    logic signed [31:0] ext[4];
    ext[0] = 32'sh8000_0000; ext[1] = 32'sh7FFF_FFFF; ext[2] = 0; ext[3] = -1;
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 4; b++) begin
        it = '{ext[a], ext[a], ext[a], ext[b], ext[b], ext[b]};
        send_pair(it);
      end
    end
    send_pair('{32'sh10000, 0, 0, 0, 0, 0});
    send_pair('{0, 32'sh20000, 0, 0, 0, 0});
    send_pair('{0, 0, -32'sh8000, 0, 0, 0});
    send_pair('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF});
    send_pair('{1, 0, 0, 0, 0, 1});
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_pair(make_pair($urandom_range(9)));
  endtask

  task automatic test_config_sweep;
    logic [31:0] rests[5];
    logic [31:0] stiffs[5];
    rests[0] = 32'h0;        stiffs[0] = 32'h7FFF_FFFF;
    rests[1] = 32'h7FFF_FFFF; stiffs[1] = 32'h0;
    rests[2] = 32'h8001_0000; stiffs[2] = 32'hFFFF_FFFF;
    rests[3] = $urandom;     stiffs[3] = $urandom_range(32'h3_0000);
    rests[4] = 32'h0;        stiffs[4] = 32'h1;
    for (int s = 0; s < 5; s++) begin
      drain();
      write_reg(REG_REST_LENGTH, rests[s]);
      write_reg(REG_SPRING_STIFFNESS, stiffs[s]);
      write_reg(REG_UNUSED, $urandom);
      test_directed();
      test_random(40);
    end
  endtask

  task automatic test_flow_phases;
    int idle_set[4];
    int stall_set[4];
    idle_set[0] = 0;  stall_set[0] = 0;
    idle_set[1] = 80; stall_set[1] = 0;
    idle_set[2] = 0;  stall_set[2] = 80;
    idle_set[3] = 36; stall_set[3] = 36;
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      idle_pct  = idle_set[ph];
      stall_pct = stall_set[ph];
      write_reg(REG_REST_LENGTH, $urandom_range(32'h40_0000));
      write_reg(REG_SPRING_STIFFNESS, $urandom_range(32'h8_0000));
      test_random(120);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    mismatch_cnt = 0;
    result_cnt   = 0;
    request_cnt  = 0;
    clip_cnt     = 0;
    quiet_cycles = 0;
    rest_len_q   = REST_LENGTH_RESET;
    stiffness_q  = STIFFNESS_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_flow_phases();
    drain();
    $display("covered %0d requests and %0d results, %0d of them saturated,",
             request_cnt, result_cnt, clip_cnt);
    $display("over rest length and stiffness extremes and four flow-control mixes");
    if (mismatch_cnt == 0 && force_queue.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/sfg_pkg.sv
rtl/core/spring_force_generator.sv
bench/tb.sv
